/* rtl/zero_fill_operand_stack_top_assert.svh */
// assertion macros used by the stack checker
`ifndef ZERO_FILL_OPERAND_STACK_TOP_ASSERT_SVH
`define ZERO_FILL_OPERAND_STACK_TOP_ASSERT_SVH

// consequence must hold in the same cycle as the antecedent
`define ZFOS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// consequence must hold in the cycle after the antecedent
`define ZFOS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/zfos_pkg.sv */
// shared constants for the zero fill operand stack
`timescale 1ns / 1ps

package zfos_pkg;

    // default sizes
    localparam int STACK_DEPTH_DEF = 256;
    localparam int WORD_BITS_DEF   = 64;

    // fixed field widths
    localparam int CMD_BITS        = 2;
    localparam int VALUE_BITS      = 64;
    localparam int DEPTH_BITS      = 8;
    localparam int STATUS_BITS     = 2;
    localparam int FILL_BITS       = 9;
    localparam int IN_TDATA_BITS   = 80;
    localparam int OUT_TDATA_BITS  = 80;

    // commands
    localparam logic [CMD_BITS-1:0] CMD_PUSH = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_POP  = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_SWAP = 2'd2;

    // result status codes
    localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_UNDERFLOW = 2'd2;

endpackage

/* rtl/zfos_ram.sv */
// stack word memory, one write port and one registered read port
`timescale 1ns / 1ps

module zfos_ram #(
    parameter int DEPTH = zfos_pkg::STACK_DEPTH_DEF,
    parameter int WIDTH = zfos_pkg::WORD_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/zero_fill_operand_stack_top.sv */
// Push, pop, unused command, no-op swap: the beat passes through EXEC and the result is registered.
// Other swaps: EXEC, one FILL step per zero word added below, then RDA, RDB, WRA and WRB in turn,
// as the fill and the two reads and two writes share the single memory port pair.
// A new beat is taken only while no command is at work; a waiting result does not block it.
// Reset (rst_n low, asynchronous): one entry, bottom at slot zero, that slot reads as zero
// until first written; no clearing pass, the other slots are never read before written.
`timescale 1ns / 1ps

module zero_fill_operand_stack_top #(
    parameter int STACK_DEPTH = zfos_pkg::STACK_DEPTH_DEF,
    parameter int WORD_BITS   = zfos_pkg::WORD_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // value[63:0], depth_a[71:64], depth_b[79:72]
    input  logic [zfos_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,
    // cmd[1:0]
    input  logic [zfos_pkg::CMD_BITS-1:0]        s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // data[63:0], fill[72:64], zero[79:73]
    output logic [zfos_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,
    // status[1:0]
    output logic [zfos_pkg::STATUS_BITS-1:0]     m_axis_tuser
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int EW = (CW > zfos_pkg::FILL_BITS) ? CW : zfos_pkg::FILL_BITS;
    localparam logic [AW:0]   DEPTH_W   = (AW + 1)'(STACK_DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(STACK_DEPTH - 1);
    localparam logic [EW-1:0] DEPTH_E   = EW'(STACK_DEPTH);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_FILL = 3'd2;
    localparam logic [2:0] S_RDA  = 3'd3;
    localparam logic [2:0] S_RDB  = 3'd4;
    localparam logic [2:0] S_WRA  = 3'd5;
    localparam logic [2:0] S_WRB  = 3'd6;
    localparam logic [2:0] S_HOLD = 3'd7;

    logic [2:0]                         state_reg, state_next;
    logic [zfos_pkg::CMD_BITS-1:0]      cmd_reg;
    logic [WORD_BITS-1:0]               value_reg;
    logic [zfos_pkg::DEPTH_BITS-1:0]    da_reg, db_reg;
    logic [CW-1:0]                      count_reg, count_next;
    logic [AW-1:0]                      bottom_reg, bottom_next;
    logic                               fresh_reg, fresh_next;
    logic                               rd_zero_reg;
    logic [EW-1:0]                      need_reg, need_next;
    logic [AW-1:0]                      sa_reg, sa_next, sb_reg, sb_next;
    logic [WORD_BITS-1:0]               tmp_reg, tmp_next;
    logic [WORD_BITS-1:0]               hold_data_reg;
    logic [zfos_pkg::STATUS_BITS-1:0]   hold_status_reg;
    logic [zfos_pkg::FILL_BITS-1:0]     hold_fill_reg;
    logic                               out_valid_reg;
    logic [zfos_pkg::VALUE_BITS-1:0]    out_data_reg;
    logic [zfos_pkg::STATUS_BITS-1:0]   out_status_reg;
    logic [zfos_pkg::FILL_BITS-1:0]     out_fill_reg;

    logic                               wr_en, rd_en;
    logic [AW-1:0]                      wr_addr, rd_addr;
    logic [WORD_BITS-1:0]               wr_data, ram_rd_data, rd_word;

    logic                               in_beat, out_free;
    logic                               fin;
    logic [WORD_BITS-1:0]               fin_data;
    logic [zfos_pkg::STATUS_BITS-1:0]   fin_status;
    logic [EW-1:0]                      count_next_w;
    logic [EW-1:0]                      cnt_w, a_w, b_w, max_w;
    logic [AW-1:0]                      top_slot, push_slot, below_slot;

    // ring position of an offset above the bottom entry
    function automatic logic [AW-1:0] ring_slot(input logic [AW-1:0] base,
                                                input logic [AW-1:0] off);
        logic [AW:0] s;
        s = {1'b0, base} + {1'b0, off};
        if (s >= DEPTH_W)
        begin
            s = s - DEPTH_W;
        end
        return s[AW-1:0];
    endfunction

    // ring position of a depth counted from the top, depth below the count
    function automatic logic [AW-1:0] depth_slot(input logic [AW-1:0] base,
                                                 input logic [CW-1:0] cnt,
                                                 input logic [zfos_pkg::DEPTH_BITS-1:0] d);
        logic [EW-1:0] off;
        off = EW'(cnt) - EW'(1) - EW'(d);
        return ring_slot(base, off[AW-1:0]);
    endfunction

    zfos_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (WORD_BITS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    // handshakes
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // slot addresses from the current pointers
    assign top_slot   = (count_reg == '0) ? bottom_reg
                        : ring_slot(bottom_reg, AW'(count_reg - CW'(1)));
    assign push_slot  = ring_slot(bottom_reg, count_reg[AW-1:0]);
    assign below_slot = (bottom_reg == '0) ? LAST_SLOT : bottom_reg - AW'(1);

    // the reset bottom word reads as zero until written
    assign rd_word = rd_zero_reg ? '0 : ram_rd_data;

    // swap operands widened for compares
    assign cnt_w = EW'(count_reg);
    assign a_w   = EW'(da_reg);
    assign b_w   = EW'(db_reg);
    assign max_w = (a_w > b_w) ? a_w : b_w;

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        bottom_next = bottom_reg;
        need_next   = need_reg;
        sa_next     = sa_reg;
        sb_next     = sb_reg;
        tmp_next    = tmp_reg;
        wr_en       = 1'b0;
        wr_addr     = push_slot;
        wr_data     = value_reg;
        rd_en       = 1'b0;
        rd_addr     = top_slot;
        fin         = 1'b0;
        fin_data    = '0;
        fin_status  = zfos_pkg::STATUS_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                // keep the top word ready for a pop
                rd_en = 1'b1;
                if (in_beat)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (cmd_reg)
                    zfos_pkg::CMD_PUSH:
                    begin
                        fin = 1'b1;
                        if (cnt_w >= DEPTH_E)
                        begin
                            fin_status = zfos_pkg::STATUS_OVERFLOW;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    zfos_pkg::CMD_POP:
                    begin
                        fin = 1'b1;
                        if (count_reg == '0)
                        begin
                            fin_status = zfos_pkg::STATUS_UNDERFLOW;
                        end
                        else
                        begin
                            fin_data   = rd_word;
                            count_next = count_reg - CW'(1);
                        end
                    end
                    zfos_pkg::CMD_SWAP:
                    begin
                        need_next = max_w + EW'(1);
                        if (count_reg == '0 || a_w == b_w
                            || (a_w >= cnt_w && b_w >= cnt_w)
                            || max_w + EW'(1) > DEPTH_E)
                        begin
                            fin = 1'b1;
                        end
                        else if (max_w >= cnt_w)
                        begin
                            state_next = S_FILL;
                        end
                        else
                        begin
                            state_next = S_RDA;
                        end
                    end
                    default:
                    begin
                        fin = 1'b1;
                    end
                endcase
            end
            S_FILL:
            begin
                // one zero word below the bottom per cycle
                wr_en       = 1'b1;
                wr_addr     = below_slot;
                wr_data     = '0;
                bottom_next = below_slot;
                count_next  = count_reg + CW'(1);
                if (cnt_w + EW'(1) == need_reg)
                begin
                    state_next = S_RDA;
                end
            end
            S_RDA:
            begin
                sa_next    = depth_slot(bottom_reg, count_reg, da_reg);
                sb_next    = depth_slot(bottom_reg, count_reg, db_reg);
                rd_en      = 1'b1;
                rd_addr    = sa_next;
                state_next = S_RDB;
            end
            S_RDB:
            begin
                tmp_next   = rd_word;
                rd_en      = 1'b1;
                rd_addr    = sb_reg;
                state_next = S_WRA;
            end
            S_WRA:
            begin
                wr_en      = 1'b1;
                wr_addr    = sa_reg;
                wr_data    = rd_word;
                state_next = S_WRB;
            end
            S_WRB:
            begin
                wr_en   = 1'b1;
                wr_addr = sb_reg;
                wr_data = tmp_reg;
                fin     = 1'b1;
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (fin)
        begin
            state_next = out_free ? S_IDLE : S_HOLD;
        end
    end

    assign count_next_w = EW'(count_next);
    assign fresh_next   = fresh_reg && !(wr_en && wr_addr == '0);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= CW'(1);
            bottom_reg    <= '0;
            fresh_reg     <= 1'b1;
            rd_zero_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            bottom_reg <= bottom_next;
            fresh_reg  <= fresh_next;
            if (rd_en)
            begin
                rd_zero_reg <= fresh_reg && (rd_addr == '0);
            end
            if ((fin || state_reg == S_HOLD) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item, swap and result payload
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            cmd_reg   <= s_axis_tuser;
            value_reg <= s_axis_tdata[WORD_BITS-1:0];
            da_reg    <= s_axis_tdata[71:64];
            db_reg    <= s_axis_tdata[79:72];
        end
        need_reg <= need_next;
        sa_reg   <= sa_next;
        sb_reg   <= sb_next;
        tmp_reg  <= tmp_next;
        if (fin)
        begin
            hold_data_reg   <= fin_data;
            hold_status_reg <= fin_status;
            hold_fill_reg   <= count_next_w[zfos_pkg::FILL_BITS-1:0];
        end
        if (fin && out_free)
        begin
            out_data_reg   <= zfos_pkg::VALUE_BITS'(fin_data);
            out_status_reg <= fin_status;
            out_fill_reg   <= count_next_w[zfos_pkg::FILL_BITS-1:0];
        end
        else if (state_reg == S_HOLD && out_free)
        begin
            out_data_reg   <= zfos_pkg::VALUE_BITS'(hold_data_reg);
            out_status_reg <= hold_status_reg;
            out_fill_reg   <= hold_fill_reg;
        end
    end

    // result beat
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_fill_reg, out_data_reg};
    assign m_axis_tuser  = out_status_reg;

endmodule

/* rtl/zfos_checker.sv */
// port level checks for the zero fill operand stack, bound to the top level
`timescale 1ns / 1ps
`include "zero_fill_operand_stack_top_assert.svh"

module zfos_checker #(
    parameter int STACK_DEPTH = zfos_pkg::STACK_DEPTH_DEF
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [zfos_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
    input logic [zfos_pkg::STATUS_BITS-1:0]    m_axis_tuser
);

    localparam int FW = zfos_pkg::FILL_BITS;
    localparam logic [31:0] DEPTH_32 = 32'(STACK_DEPTH);
    localparam logic [FW-1:0] FULL_FILL = DEPTH_32[FW-1:0];

    // a stalled result beat holds
    `ZFOS_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result beat changed")

    // one command at a time: no beat taken right after another
    `ZFOS_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "beat taken while a command is at work")

    // a dropped push leaves the stack full and no data
    `ZFOS_ASSERT_SAME(a_overflow_full, clk, rst_n, m_axis_tvalid && m_axis_tuser == zfos_pkg::STATUS_OVERFLOW, m_axis_tdata[63:0] == 64'd0 && m_axis_tdata[72:64] == FULL_FILL, "overflow with stack not full")

    // an empty pop leaves the stack empty and no data
    `ZFOS_ASSERT_SAME(a_underflow_empty, clk, rst_n, m_axis_tvalid && m_axis_tuser == zfos_pkg::STATUS_UNDERFLOW, m_axis_tdata[72:0] == 73'd0, "underflow with data or entries")

endmodule

bind zero_fill_operand_stack_top zfos_checker #(
    .STACK_DEPTH (STACK_DEPTH)
) u_zfos_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

/* verif/tb_zero_fill_operand_stack_top.sv */
// testbench for the zero fill operand stack: self-checking push, pop and deep swap traffic
`timescale 1ns / 1ps

module tb_zero_fill_operand_stack_top;

    // ring size and word width of the block under test
    localparam int STACK_SLOTS = zfos_pkg::STACK_DEPTH_DEF;
    localparam int SETTLE_CYCLES = 300;
    localparam int VW = zfos_pkg::VALUE_BITS;
    localparam int DW = zfos_pkg::DEPTH_BITS;
    localparam int SW = zfos_pkg::STATUS_BITS;
    localparam int FW = zfos_pkg::FILL_BITS;
    localparam int OW = zfos_pkg::OUT_TDATA_BITS;
    localparam logic [zfos_pkg::CMD_BITS-1:0] CMD_UNUSED = 2'd3;

    // one response of the stack
    typedef struct packed {
        logic [VW-1:0] data;
        logic [SW-1:0] status;
        logic [FW-1:0] fill;
    } stack_reply_t;

    logic                                clk = 1'b0;
    logic                                rst_n;
    logic                                s_axis_tvalid;
    logic                                s_axis_tready;
    logic [zfos_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata;
    logic [zfos_pkg::CMD_BITS-1:0]       s_axis_tuser;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [OW-1:0]                       m_axis_tdata;
    logic [SW-1:0]                       m_axis_tuser;

    // shadow copy of the stack
    logic [VW-1:0] stk_mem [STACK_SLOTS];
    int unsigned   stk_count;
    int unsigned   stk_bottom;

    stack_reply_t stack_replies_q [$];
    stack_reply_t want_reply;
    int           mismatch_count = 0;
    int           ready_stall = 0;
    int unsigned  beats_taken = 0;
    int unsigned  beats_seen = 0;
    bit           gaps_on;

    zero_fill_operand_stack_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ring slot of the entry at a given depth from the top
    function automatic int unsigned slot_of(input int unsigned depth);
        return (stk_bottom + stk_count - 1 - depth) % STACK_SLOTS;
    endfunction

    // apply one command to the shadow stack and return its response
    function automatic stack_reply_t stack_apply(input logic [zfos_pkg::CMD_BITS-1:0] cmd,
                                                 input logic [VW-1:0] value,
                                                 input logic [DW-1:0] da,
                                                 input logic [DW-1:0] db);
        stack_reply_t  r;
        int unsigned   need;
        int unsigned   sa;
        int unsigned   sb;
        logic [VW-1:0] tmp;
        r.data   = '0;
        r.status = zfos_pkg::STATUS_OK;
        need     = ((da > db) ? da : db) + 1;
        case (cmd)
            zfos_pkg::CMD_PUSH:
            begin
                if (stk_count >= STACK_SLOTS)
                    r.status = zfos_pkg::STATUS_OVERFLOW;
                else
                begin
                    stk_mem[(stk_bottom + stk_count) % STACK_SLOTS] = value;
                    stk_count++;
                end
            end
            zfos_pkg::CMD_POP:
            begin
                if (stk_count == 0)
                    r.status = zfos_pkg::STATUS_UNDERFLOW;
                else
                begin
                    r.data = stk_mem[slot_of(0)];
                    stk_count--;
                end
            end
            zfos_pkg::CMD_SWAP:
            begin
                // no-op on empty stack, equal depths, both depths beyond, or past capacity
                if (stk_count != 0 && da != db && !(da >= stk_count && db >= stk_count)
                    && need <= STACK_SLOTS)
                begin
                    // zero words added at the bottom until the deeper depth exists
                    while (stk_count < need)
                    begin
                        stk_bottom = (stk_bottom + STACK_SLOTS - 1) % STACK_SLOTS;
                        stk_mem[stk_bottom] = '0;
                        stk_count++;
                    end
                    sa = slot_of(da);
                    sb = slot_of(db);
                    tmp = stk_mem[sa];
                    stk_mem[sa] = stk_mem[sb];
                    stk_mem[sb] = tmp;
                end
            end
            default: ;
        endcase
        r.fill = stk_count[FW-1:0];
        return r;
    endfunction

    // random word with the extremes mixed in
    function automatic logic [VW-1:0] rand_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // random depth over the whole field
    function automatic logic [DW-1:0] rand_depth();
        logic [31:0] r;
        r = $urandom;
        return r[DW-1:0];
    endfunction

    // send one beat, after a random gap while gaps are on, and record its expected response
    task automatic issue_command(input logic [zfos_pkg::CMD_BITS-1:0] cmd,
                                 input logic [VW-1:0] value,
                                 input logic [DW-1:0] da,
                                 input logic [DW-1:0] db);
        int           gap;
        stack_reply_t reply;
        gap = gaps_on ? $urandom_range(0, 11) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {db, da, value};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        reply = stack_apply(cmd, value, da, db);
        stack_replies_q = {stack_replies_q, reply};
    endtask

    // stop sending and wait for every outstanding response
    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (stack_replies_q.size() != 0)
            @(posedge clk);
    endtask

    // pop of the reset entry, then a pop and a swap on the empty stack, unused command
    task automatic test_empty_stack();
        issue_command(zfos_pkg::CMD_POP, '0, 8'd0, 8'd0);
        issue_command(zfos_pkg::CMD_POP, '1, 8'd255, 8'd255);
        issue_command(zfos_pkg::CMD_SWAP, '0, 8'd0, 8'd1);
        issue_command(CMD_UNUSED, '1, 8'hff, 8'hff);
        issue_command(CMD_UNUSED, '0, 8'h00, 8'h00);
    endtask

    // swap corner cases and the full stack
    task automatic test_swap_and_full();
        issue_command(zfos_pkg::CMD_PUSH, '1, 8'd0, 8'd0);
        issue_command(zfos_pkg::CMD_PUSH, '0, 8'hff, 8'hff);
        issue_command(zfos_pkg::CMD_PUSH, 64'h8000_0000_0000_0001, 8'd0, 8'd0);
        issue_command(zfos_pkg::CMD_SWAP, '0, 8'd0, 8'd2);
        issue_command(zfos_pkg::CMD_SWAP, '0, 8'd1, 8'd1);
        issue_command(zfos_pkg::CMD_SWAP, '0, 8'd10, 8'd20);
        issue_command(zfos_pkg::CMD_SWAP, '0, 8'd0, 8'd5);
        issue_command(zfos_pkg::CMD_POP, '0, 8'd0, 8'd0);
        issue_command(zfos_pkg::CMD_SWAP, '0, 8'd255, 8'd0);
        issue_command(zfos_pkg::CMD_PUSH, 64'hdead_beef_0123_4567, 8'd0, 8'd0);
        issue_command(CMD_UNUSED, 64'h5555_5555_5555_5555, 8'h55, 8'haa);
        issue_command(zfos_pkg::CMD_POP, '0, 8'd0, 8'd0);
        issue_command(zfos_pkg::CMD_POP, '0, 8'd0, 8'd0);
        issue_command(zfos_pkg::CMD_SWAP, '0, 8'd255, 8'd254);
        issue_command(zfos_pkg::CMD_SWAP, '0, 8'd253, 8'd255);
        issue_command(zfos_pkg::CMD_PUSH, 64'haaaa_aaaa_aaaa_aaaa, 8'd0, 8'd0);
        issue_command(zfos_pkg::CMD_POP, '0, 8'd0, 8'd0);
    endtask

    // push until overflow, then pop until underflow
    task automatic test_fill_drain();
        while (stk_count < STACK_SLOTS)
            issue_command(zfos_pkg::CMD_PUSH, rand_word(), rand_depth(), rand_depth());
        repeat (3) issue_command(zfos_pkg::CMD_PUSH, rand_word(), rand_depth(), rand_depth());
        while (stk_count > 0)
            issue_command(zfos_pkg::CMD_POP, rand_word(), rand_depth(), rand_depth());
        repeat (3) issue_command(zfos_pkg::CMD_POP, rand_word(), rand_depth(), rand_depth());
    endtask

    // random mix of commands, swap depths mostly within the stack
    task automatic test_random_mix(input int n_items);
        int unsigned pick;
        int unsigned lo;
        logic [DW-1:0] da;
        logic [DW-1:0] db;
        logic [DW-1:0] t;
        for (int i = 0; i < n_items; i++)
        begin
            // stretches with and without idling
            if (i % 64 == 0)
                gaps_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 40)
                issue_command(zfos_pkg::CMD_PUSH, rand_word(), rand_depth(), rand_depth());
            else if (pick < 77)
                issue_command(zfos_pkg::CMD_POP, rand_word(), rand_depth(), rand_depth());
            else if (pick < 95)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 6 && stk_count > 0)
                begin
                    da = DW'($urandom_range(0, stk_count - 1));
                    db = DW'($urandom_range(0, stk_count - 1));
                end
                else if (pick < 8)
                begin
                    // one depth inside, one beyond the stack
                    lo = (stk_count > 255) ? 255 : stk_count;
                    da = DW'((stk_count > 0) ? $urandom_range(0, stk_count - 1) : 0);
                    db = DW'($urandom_range(lo, 255));
                    if ($urandom_range(0, 1))
                    begin
                        t  = da;
                        da = db;
                        db = t;
                    end
                end
                else
                begin
                    da = rand_depth();
                    db = rand_depth();
                end
                issue_command(zfos_pkg::CMD_SWAP, rand_word(), da, db);
            end
            else
                issue_command(CMD_UNUSED, rand_word(), rand_depth(), rand_depth());
        end
        gaps_on = 1'b1;
    endtask

    // response sink with random stalls, a new stall drawn after each taken beat
    always @(negedge clk)
    begin
        if (beats_seen != beats_taken)
        begin
            beats_seen  = beats_taken;
            ready_stall = gaps_on ? $urandom_range(0, 11) : 0;
        end
        if (ready_stall > 0)
        begin
            m_axis_tready <= 1'b0;
            ready_stall--;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // response checker
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (stack_replies_q.size() == 0)
            begin
                $display("%0t: unexpected beat, tdata %h tuser %h", $time, m_axis_tdata,
                         m_axis_tuser);
                mismatch_count++;
            end
            else
            begin
                want_reply = stack_replies_q.pop_front();
                if (m_axis_tdata[VW-1:0] !== want_reply.data)
                begin
                    $display("%0t: data mismatch, expected %h actual %h", $time,
                             want_reply.data, m_axis_tdata[VW-1:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[VW+FW-1:VW] !== want_reply.fill)
                begin
                    $display("%0t: fill mismatch, expected %0d actual %0d", $time,
                             want_reply.fill, m_axis_tdata[VW+FW-1:VW]);
                    mismatch_count++;
                end
                if (m_axis_tdata[OW-1:VW+FW] !== '0)
                begin
                    $display("%0t: padding mismatch, expected 0 actual %h", $time,
                             m_axis_tdata[OW-1:VW+FW]);
                    mismatch_count++;
                end
                if (m_axis_tuser !== want_reply.status)
                begin
                    $display("%0t: status mismatch, expected %0d actual %0d", $time,
                             want_reply.status, m_axis_tuser);
                    mismatch_count++;
                end
            end
            beats_taken++;
        end
    end

    // test sequence
    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = zfos_pkg::CMD_PUSH;
        gaps_on        = 1'b1;
        stk_count      = 1;
        stk_bottom     = 0;
        foreach (stk_mem[i])
            stk_mem[i] = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        test_empty_stack();
        test_swap_and_full();
        wait_drained();
        test_fill_drain();
        wait_drained();
        test_random_mix(560);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // run limit
    initial
    begin
        #10_000_000;
        $display("%0t: timeout", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
